/* src/shb_pkg.sv */
// Shared types and constants of the bitmap handle slot allocator.
package shb_pkg;

  // Widths of the fields on the ports.
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 10;
  localparam int VALUE_W = 48;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;

  // The use bitmap is kept in words of this many bits.
  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_WRITE = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_e;

endpackage

/* src/shb_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
module shb_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/shb_ffz.sv */
// Find-first-zero encoder over one bitmap word.
module shb_ffz (
  input  logic [shb_pkg::WORD_BITS-1:0] word_i,
  output logic [shb_pkg::BIT_IDX_W-1:0] pos_o
);

  always_comb begin
    pos_o = '0;
    // Scanning downward leaves the lowest clear bit as the final answer.
    for (int i = shb_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        pos_o = shb_pkg::BIT_IDX_W'(i);
      end
    end
  end

endmodule

/* src/bitmap_handle_slot_allocator_core.sv */
// Bitmap handle slot allocator: top level with the operation sequencer.
//
// Usage: one request channel (func_i, slot_i, value_i with in_valid_i and
// in_stall_o) and one result channel (slot_out_o, old_value_o, status_o,
// in_use_o with out_valid_o and out_stall_i). Every request gives exactly
// one result, in order. A transfer happens when valid is high and stall low.
// Free, write and read pass from the request transfer through S_CHECK and
// S_RESP to the output register. Allocate passes through S_SCAN, which
// steps over each completely used bitmap word, and then S_RESP; a search
// hint that points at the lowest word that may hold a free slot lets the
// scan start there. The bitmap memory, with its single read port, is
// examined one 32-slot word per cycle. A full pool, or a slot index beyond
// the pool, goes straight to S_RESP. One request is in flight at a time:
// the block takes no new request until the last has loaded its result.
// After reset the block clears its ceil(SLOTS/32) bitmap words, one word per
// cycle (32 words at 1024 slots), with in_stall_o high.
// A result that the receiver stalls stays in the output register; the block
// still takes the next request and holds its result until the register frees.
module bitmap_handle_slot_allocator_core #(
  parameter int SLOTS      = 1024,
  parameter int VALUE_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [shb_pkg::FUNC_W-1:0]    func_i,
  input  logic [shb_pkg::SLOT_W-1:0]    slot_i,
  input  logic [shb_pkg::VALUE_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [shb_pkg::SLOT_W-1:0]    slot_out_o,
  output logic [shb_pkg::VALUE_W-1:0]   old_value_o,
  output logic [shb_pkg::STATUS_W-1:0]  status_o,
  output logic [shb_pkg::COUNT_W-1:0]   in_use_o
);

  localparam int WORDS = (SLOTS + shb_pkg::WORD_BITS - 1) / shb_pkg::WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int WB    = shb_pkg::WORD_BITS;
  localparam int BW    = shb_pkg::BIT_IDX_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_CHECK = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] hint_q, hint_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  shb_pkg::func_e         func_q, func_d;
  logic [shb_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [shb_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [VALUE_BITS-1:0]  res_old_q, res_old_d;
  shb_pkg::status_e       res_status_q, res_status_d;
  logic [shb_pkg::SLOT_W-1:0] out_slot_q;
  logic [VALUE_BITS-1:0]  out_old_q;
  shb_pkg::status_e       out_status_q;
  logic [CW-1:0]          out_count_q;
  logic                   out_load;

  // Bitmap and value memory ports.
  logic          bm_we, bm_re;
  logic [AW-1:0] bm_waddr, bm_raddr;
  logic [WB-1:0] bm_wdata, bm_rdata;
  logic                  vm_we, vm_re;
  logic [SW-1:0]         vm_waddr, vm_raddr;
  logic [VALUE_BITS-1:0] vm_wdata, vm_rdata;

  logic [BW-1:0] ffz_pos;

  // Index decoding of the incoming and the held slot.
  logic [31:0]           in_slot32, in_word32, q_slot32, q_word32, grant32;
  logic                  in_slot_ok;
  logic [SW-1:0]         in_idx, q_idx, grant_idx;
  logic [AW-1:0]         in_word, q_word;
  logic [BW-1:0]         q_bit;
  logic [63:0]           in_val64, old64;
  logic [VALUE_BITS-1:0] in_val;
  logic                  count_full;
  logic [31:0]           count32;
  logic [WB-1:0]         grant_mask, free_mask;

  assign in_slot32  = 32'(slot_i);
  assign in_slot_ok = in_slot32 < 32'(SLOTS);
  assign in_idx     = in_slot32[SW-1:0];
  assign in_word32  = in_slot32 >> BW;
  assign in_word    = in_word32[AW-1:0];
  assign q_slot32   = 32'(slot_q);
  assign q_idx      = q_slot32[SW-1:0];
  assign q_word32   = q_slot32 >> BW;
  assign q_word     = q_word32[AW-1:0];
  assign q_bit      = q_slot32[BW-1:0];
  assign grant32    = (32'(ptr_q) << BW) | 32'(ffz_pos);
  assign grant_idx  = grant32[SW-1:0];
  assign in_val64   = 64'(value_i);
  assign in_val     = in_val64[VALUE_BITS-1:0];
  assign count_full = 32'(count_q) == 32'(SLOTS);
  assign grant_mask = WB'(1) << ffz_pos;
  assign free_mask  = WB'(1) << q_bit;

  shb_ram #(
    .DEPTH (WORDS),
    .WIDTH (WB),
    .AW    (AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  shb_ram #(
    .DEPTH (SLOTS),
    .WIDTH (VALUE_BITS),
    .AW    (SW)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (vm_we),
    .waddr_i (vm_waddr),
    .wdata_i (vm_wdata),
    .re_i    (vm_re),
    .raddr_i (vm_raddr),
    .rdata_o (vm_rdata)
  );

  shb_ffz u_ffz (
    .word_i (bm_rdata),
    .pos_o  (ffz_pos)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    ptr_d        = ptr_q;
    hint_d       = hint_q;
    count_d      = count_q;
    func_d       = func_q;
    slot_d       = slot_q;
    val_d        = val_q;
    res_slot_d   = res_slot_q;
    res_old_d    = res_old_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    bm_we        = 1'b0;
    bm_waddr     = ptr_q;
    bm_wdata     = '0;
    bm_re        = 1'b0;
    bm_raddr     = ptr_q;
    vm_we        = 1'b0;
    vm_waddr     = q_idx;
    vm_wdata     = val_q;
    vm_re        = 1'b0;
    vm_raddr     = in_idx;

    case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        if (32'(clr_q) == 32'(WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = shb_pkg::func_e'(func_i);
          slot_d = slot_i;
          val_d  = in_val;
          if (shb_pkg::func_e'(func_i) == shb_pkg::FN_ALLOC) begin
            if (count_full) begin
              res_slot_d   = '0;
              res_old_d    = '0;
              res_status_d = shb_pkg::ST_FULL;
              state_d      = S_RESP;
            end else begin
              bm_re    = 1'b1;
              bm_raddr = hint_q;
              ptr_d    = hint_q;
              state_d  = S_SCAN;
            end
          end else if (!in_slot_ok) begin
            res_slot_d   = slot_i;
            res_old_d    = '0;
            res_status_d = shb_pkg::ST_UNUSED;
            state_d      = S_RESP;
          end else begin
            bm_re    = 1'b1;
            bm_raddr = in_word;
            vm_re    = 1'b1;
            vm_raddr = in_idx;
            state_d  = S_CHECK;
          end
        end
      end
      S_SCAN: begin
        // The count says a free slot exists, and every word below the hint is
        // full, so the scan always ends on a word with a clear bit.
        if (&bm_rdata) begin
          ptr_d    = ptr_q + AW'(1);
          hint_d   = ptr_q + AW'(1);
          bm_re    = 1'b1;
          bm_raddr = ptr_q + AW'(1);
        end else begin
          bm_we        = 1'b1;
          bm_waddr     = ptr_q;
          bm_wdata     = bm_rdata | grant_mask;
          vm_we        = 1'b1;
          vm_waddr     = grant_idx;
          vm_wdata     = val_q;
          count_d      = count_q + CW'(1);
          res_slot_d   = grant32[shb_pkg::SLOT_W-1:0];
          res_old_d    = '0;
          res_status_d = shb_pkg::ST_OK;
          state_d      = S_RESP;
        end
      end
      S_CHECK: begin
        res_slot_d = slot_q;
        state_d    = S_RESP;
        if (!bm_rdata[q_bit]) begin
          res_old_d    = '0;
          res_status_d = shb_pkg::ST_UNUSED;
        end else begin
          res_old_d    = vm_rdata;
          res_status_d = shb_pkg::ST_OK;
          case (func_q)
            shb_pkg::FN_FREE: begin
              bm_we    = 1'b1;
              bm_waddr = q_word;
              bm_wdata = bm_rdata & ~free_mask;
              count_d  = count_q - CW'(1);
              if (q_word < hint_q) begin
                hint_d = q_word;
              end
            end
            shb_pkg::FN_WRITE: begin
              vm_we    = 1'b1;
              vm_waddr = q_idx;
              vm_wdata = val_q;
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ptr_q       <= '0;
      hint_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ptr_q       <= ptr_d;
      hint_q      <= hint_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    slot_q       <= slot_d;
    val_q        <= val_d;
    res_slot_q   <= res_slot_d;
    res_old_q    <= res_old_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_slot_q   <= res_slot_q;
      out_old_q    <= res_old_q;
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
    end
  end

  assign old64   = 64'(out_old_q);
  assign count32 = 32'(out_count_q);

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign slot_out_o  = out_slot_q;
  assign old_value_o = old64[shb_pkg::VALUE_W-1:0];
  assign status_o    = out_status_q;
  assign in_use_o    = count32[shb_pkg::COUNT_W-1:0];

endmodule

/* src/shb_checker.sv */
// Port-level checker of the bitmap handle slot allocator, bound to its top level.
module shb_checker #(
  parameter int SLOTS = 1024
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [shb_pkg::FUNC_W-1:0]    func_i,
  input logic [shb_pkg::SLOT_W-1:0]    slot_i,
  input logic [shb_pkg::VALUE_W-1:0]   value_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [shb_pkg::SLOT_W-1:0]    slot_out_o,
  input logic [shb_pkg::VALUE_W-1:0]   old_value_o,
  input logic [shb_pkg::STATUS_W-1:0]  status_o,
  input logic [shb_pkg::COUNT_W-1:0]   in_use_o
);

  localparam logic [shb_pkg::COUNT_W-1:0] FULL_COUNT = shb_pkg::COUNT_W'(SLOTS);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_out_o)
      && $stable(old_value_o) && $stable(status_o) && $stable(in_use_o))
    else $error("stalled result changed");

  // A full pool grants nothing and returns no value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == shb_pkg::ST_FULL |->
      slot_out_o == '0 && old_value_o == '0 && in_use_o == FULL_COUNT)
    else $error("pool full result is inconsistent");

  // An access to an unallocated slot returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == shb_pkg::ST_UNUSED |-> old_value_o == '0)
    else $error("unallocated slot returned a value");

  // A result only appears while a request is being served: when out_valid_o
  // rises, $past(in_stall_o) must be high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

endmodule

bind bitmap_handle_slot_allocator_core shb_checker #(.SLOTS(SLOTS)) u_shb_checker (.*);
